// ===== design/lprt_pkg.sv =====
// Package for the longest-prefix route table: operation codes, word types,
// the token that walks the cell chain, and the mask prefix functions.
// No dependencies.
package lprt_pkg;

  localparam int ENTRIES_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_FIND   = 3'd3,
    OP_GET    = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [31:0] next_hop;
    logic [3:0]  port_number;
    logic [7:0]  slot;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  slot_out;
    logic [31:0] route_subnet;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [3:0]  route_port;
    logic [5:0]  prefix_len;
  } out_word_t;

  // Request plus running result, handed from cell to cell.
  typedef struct packed {
    op_e         kind;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [31:0] next_hop;
    logic [3:0]  port_number;
    logic [7:0]  slot;
    logic        hit;
    logic [7:0]  idx;
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
    logic [5:0]  plen;
  } token_t;

  function automatic logic [3:0] byte_prefix(input logic [7:0] b);
    logic [3:0] n;
    case (b)
      8'd255:  n = 4'd8;
      8'd254:  n = 4'd7;
      8'd252:  n = 4'd6;
      8'd248:  n = 4'd5;
      8'd240:  n = 4'd4;
      8'd224:  n = 4'd3;
      8'd192:  n = 4'd2;
      8'd128:  n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] mask_prefix(input logic [31:0] m);
    return {2'b00, byte_prefix(m[31:24])} + {2'b00, byte_prefix(m[23:16])} +
           {2'b00, byte_prefix(m[15:8])} + {2'b00, byte_prefix(m[7:0])};
  endfunction

endpackage

// ===== design/lprt_cell.sv =====
// One route slot of the chain: holds a route and updates the passing token.
// Depends on lprt_pkg.
module lprt_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  lprt_pkg::token_t tok_i,
  output logic            tok_valid_o,
  output lprt_pkg::token_t tok_o
);
  import lprt_pkg::*;

  localparam logic [7:0] MyIdx = 8'(IDX);

  logic        valid_q, valid_d;
  logic [31:0] sub_q, mask_q, gw_q;
  logic [3:0]  port_q;
  logic [5:0]  plen_q;
  logic        wr;
  logic        tv_q;
  token_t      tok_q, tok_d;

  always_comb begin
    tok_d   = tok_i;
    wr      = 1'b0;
    valid_d = valid_q;
    if (tok_valid_i) begin
      unique case (tok_i.kind)
        OP_ADD: begin
          // take the route in the first free slot along the chain
          if (!valid_q && !tok_i.hit) begin
            wr            = 1'b1;
            valid_d       = 1'b1;
            tok_d.hit     = 1'b1;
            tok_d.idx     = MyIdx;
            tok_d.subnet  = tok_i.address;
            tok_d.mask    = tok_i.net_mask;
            tok_d.gateway = tok_i.next_hop;
            tok_d.port    = tok_i.port_number;
          end
        end
        OP_REMOVE, OP_GET: begin
          if (valid_q && tok_i.slot == MyIdx) begin
            if (tok_i.kind == OP_REMOVE) valid_d = 1'b0;
            tok_d.hit     = 1'b1;
            tok_d.idx     = MyIdx;
            tok_d.subnet  = sub_q;
            tok_d.mask    = mask_q;
            tok_d.gateway = gw_q;
            tok_d.port    = port_q;
          end
        end
        OP_FIND: begin
          if (valid_q && !tok_i.hit && sub_q == tok_i.address && mask_q == tok_i.net_mask) begin
            tok_d.hit     = 1'b1;
            tok_d.idx     = MyIdx;
            tok_d.subnet  = sub_q;
            tok_d.mask    = mask_q;
            tok_d.gateway = gw_q;
            tok_d.port    = port_q;
          end
        end
        OP_LOOKUP: begin
          // strictly longer prefix replaces, so the earlier slot keeps a tie
          if (valid_q && (tok_i.address & mask_q) == sub_q &&
              (!tok_i.hit || plen_q > tok_i.plen)) begin
            tok_d.hit     = 1'b1;
            tok_d.idx     = MyIdx;
            tok_d.subnet  = sub_q;
            tok_d.mask    = mask_q;
            tok_d.gateway = gw_q;
            tok_d.port    = port_q;
            tok_d.plen    = plen_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tv_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tv_q    <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr) begin
      sub_q  <= tok_i.address;
      mask_q <= tok_i.net_mask;
      gw_q   <= tok_i.next_hop;
      port_q <= tok_i.port_number;
      plen_q <= mask_prefix(tok_i.net_mask);
    end
  end

  assign tok_valid_o = tv_q;
  assign tok_o       = tok_q;

endmodule

// ===== design/lprt_out_buf.sv =====
// Two-word result buffer between the cell chain and the output channel.
// Depends on lprt_pkg.
module lprt_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lprt_pkg::out_word_t push_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lprt_pkg::out_word_t out_word_o,
  output logic [1:0]         count_o
);
  import lprt_pkg::*;

  out_word_t   buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= push_word_i;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = buf_q[rd_q];
  assign count_o     = cnt_q;

endmodule

// ===== design/longest_prefix_route_table_unit.sv =====
// Channel   Dir  Handshake                   Word
// in        in   in_valid_i / in_ready_o     lprt_pkg::in_word_t
// out       out  out_valid_o / out_ready_i   lprt_pkg::out_word_t
//
// One word at a time walks a row of ENTRIES route cells, one cell a cycle.
// A new word is accepted only after the previous word's token has left the last
// cell; the result is pushed into the output buffer as the token leaves it.
// A two-word output buffer lets a new word enter while a result waits;
// input stalls only when both buffer words are held or a word is in flight.
// Reset clears all route valid bits at once; no clearing pass is needed.
// Top level of the route table; depends on lprt_pkg, lprt_cell, lprt_out_buf.
module longest_prefix_route_table_unit #(
  parameter int ENTRIES = lprt_pkg::ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lprt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lprt_pkg::out_word_t out_word_o
);
  import lprt_pkg::*;

  logic             busy_q;
  logic             launch_v_q;
  token_t           launch_q;
  token_t           launch_d;
  logic [ENTRIES:0] tv_w;
  token_t           tok_w [ENTRIES+1];
  logic [1:0]       cnt;
  logic             accept;
  logic             done;
  token_t           fin;
  out_word_t        res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q && (cnt != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      launch_v_q <= 1'b0;
    end else begin
      launch_v_q <= accept;
      if (accept)    busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
    end
  end

  // start each request with an empty result
  always_comb begin
    launch_d             = '0;
    launch_d.kind        = op_e'(in_word_i.kind);
    launch_d.address     = in_word_i.address;
    launch_d.net_mask    = in_word_i.net_mask;
    launch_d.next_hop    = in_word_i.next_hop;
    launch_d.port_number = in_word_i.port_number;
    launch_d.slot        = in_word_i.slot;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_q <= launch_d;
    end
  end

  assign tv_w[0]  = launch_v_q;
  assign tok_w[0] = launch_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lprt_cell #(.IDX(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tv_w[g]),
      .tok_i       (tok_w[g]),
      .tok_valid_o (tv_w[g+1]),
      .tok_o       (tok_w[g+1])
    );
  end

  assign done = tv_w[ENTRIES];
  assign fin  = tok_w[ENTRIES];

  always_comb begin
    res.found         = fin.hit;
    res.slot_out      = fin.idx[4:0];
    res.route_subnet  = fin.subnet;
    res.route_mask    = fin.mask;
    res.route_gateway = fin.gateway;
    res.route_port    = fin.port;
    res.prefix_len    = fin.plen;
  end

  lprt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (done),
    .push_word_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .count_o     (cnt)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !in_ready_o)
    else $error("second word accepted while one is in flight");

  a_done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q)
    else $error("result leaves the chain with no word in flight");

  a_buf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> cnt != 2'd2)
    else $error("result pushed into a full output buffer");

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tv_w) <= 1)
    else $error("more than one token in the cell chain");

endmodule

// ===== sim/route_table_checker.sv =====
// Checker for the route table: watches the request and response channels,
// predicts each response from its own copy of the routes, and compares.
// Depends on lprt_pkg.
module route_table_checker #(
  parameter int ENTRIES = lprt_pkg::ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  lprt_pkg::in_word_t  req_word_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  lprt_pkg::out_word_t rsp_word_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import lprt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic        route_used [ENTRIES];
  logic [31:0] route_net  [ENTRIES];
  logic [31:0] route_mask [ENTRIES];
  logic [31:0] route_gw   [ENTRIES];
  logic [3:0]  route_port [ENTRIES];

  out_word_t expected_routes[$];
  int        failures;

  // Sum of per-byte prefix lengths; a byte that is not a run of leading
  // ones followed by zeros counts nothing.
  function automatic logic [5:0] mask_length(input logic [31:0] m);
    logic [5:0] total;
    logic [7:0] b;
    int         ones;
    total = '0;
    for (int k = 0; k < 4; k++) begin
      b = m[8*k +: 8];
      ones = 0;
      while (ones < 8 && b[7-ones]) ones++;
      if ((b << ones) == 8'h00) total += 6'(ones);
    end
    return total;
  endfunction

  task automatic route_table_step(input in_word_t req, output out_word_t res);
    int         pick;
    logic [5:0] pick_len;
    logic [5:0] len;
    res = '0;
    pick = -1;
    pick_len = '0;
    case (req.kind)
      OP_ADD: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!route_used[i] && pick < 0) pick = i;
        end
        if (pick >= 0) begin
          route_used[pick] = 1'b1;
          route_net[pick]  = req.address;
          route_mask[pick] = req.net_mask;
          route_gw[pick]   = req.next_hop;
          route_port[pick] = req.port_number;
        end
      end
      OP_REMOVE, OP_GET: begin
        if (req.slot < ENTRIES && route_used[req.slot]) pick = req.slot;
      end
      OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (route_used[i] && (req.address & route_mask[i]) == route_net[i]) begin
            len = mask_length(route_mask[i]);
            // strict compare keeps the lowest slot on a tie
            if (pick < 0 || len > pick_len) begin
              pick = i;
              pick_len = len;
            end
          end
        end
      end
      OP_FIND: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (pick < 0 && route_used[i] && route_net[i] == req.address &&
              route_mask[i] == req.net_mask) pick = i;
        end
      end
      default: ;
    endcase
    if (pick >= 0) begin
      res.found         = 1'b1;
      res.slot_out      = 5'(pick);
      res.route_subnet  = route_net[pick];
      res.route_mask    = route_mask[pick];
      res.route_gateway = route_gw[pick];
      res.route_port    = route_port[pick];
      res.prefix_len    = (req.kind == OP_LOOKUP) ? pick_len : 6'd0;
      if (req.kind == OP_REMOVE) route_used[pick] = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t next_want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) route_used[i] = 1'b0;
      expected_routes.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_routes.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected response word: %p", rsp_word_i);
        end else begin
          want = expected_routes.pop_front();
          if (rsp_word_i !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("response mismatch: found %0d/%0d slot %0d/%0d net %h/%h",
                       want.found, rsp_word_i.found, want.slot_out,
                       rsp_word_i.slot_out, want.route_subnet,
                       rsp_word_i.route_subnet);
              $display("  mask %h/%h gw %h/%h port %0d/%0d plen %0d/%0d (exp/got)",
                       want.route_mask, rsp_word_i.route_mask,
                       want.route_gateway, rsp_word_i.route_gateway,
                       want.route_port, rsp_word_i.route_port,
                       want.prefix_len, rsp_word_i.prefix_len);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        route_table_step(req_word_i, next_want);
        expected_routes.push_back(next_want);
      end
      fail_count_o <= failures;
      pending_o <= expected_routes.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the route table testbench: clock, reset, request stimulus and
// response back-pressure, watchdog and verdict.
// Depends on lprt_pkg, longest_prefix_route_table_unit, route_table_checker.
module tb_top;
  import lprt_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int BURST_LEN = 60;
  localparam int STALL_LIMIT = 4000;
  localparam int ROUTE_MEMORY = 48;
  localparam logic [2:0] FIRST_UNUSED_KIND = 3'd5;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  in_word_t installed_routes[$];

  longest_prefix_route_table_unit #(.ENTRIES(ENTRIES)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  route_table_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_i (in_ready_o),
    .req_word_i  (in_word_i),
    .rsp_valid_i (out_valid_o),
    .rsp_ready_i (out_ready_i),
    .rsp_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t make_req(input logic [2:0] kind, input logic [31:0] addr,
                                        input logic [31:0] mask, input logic [31:0] hop,
                                        input logic [3:0] port, input logic [7:0] slot);
    in_word_t w;
    w.kind        = kind;
    w.address     = addr;
    w.net_mask    = mask;
    w.next_hop    = hop;
    w.port_number = port;
    w.slot        = slot;
    return w;
  endfunction

  // Mostly contiguous prefixes, some byte-wise patterns, a few raw masks.
  function automatic logic [31:0] pick_mask();
    logic [7:0]  nice [9] = '{8'd0, 8'd128, 8'd192, 8'd224, 8'd240,
                              8'd248, 8'd252, 8'd254, 8'd255};
    logic [31:0] m;
    int          roll;
    int          len;
    roll = $urandom_range(99);
    if (roll < 70) begin
      len = $urandom_range(32);
      m = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    end else if (roll < 85) begin
      for (int k = 0; k < 4; k++)
        m[8*k +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : nice[$urandom_range(8)];
    end else begin
      m = $urandom;
    end
    return m;
  endfunction

  function automatic in_word_t random_request(input bit filling);
    in_word_t w;
    in_word_t known;
    int       roll;
    w = make_req(OP_ADD, $urandom, $urandom, $urandom, 4'($urandom), 8'($urandom));
    roll = $urandom_range(99);
    if (roll < (filling ? 55 : 20)) begin
      w.kind = OP_ADD;
      w.net_mask = pick_mask();
      if ($urandom_range(99) < 85) w.address &= w.net_mask;
      if ($urandom_range(99) < 20) w.next_hop = '0;
    end else if (roll < (filling ? 63 : 55)) begin
      w.kind = OP_REMOVE;
    end else if (roll < (filling ? 85 : 80)) begin
      w.kind = OP_LOOKUP;
      if (installed_routes.size() > 0 && $urandom_range(99) < 75) begin
        known = installed_routes[$urandom_range(installed_routes.size() - 1)];
        w.address = known.address | ($urandom & ~known.net_mask);
      end
    end else if (roll < (filling ? 92 : 88)) begin
      w.kind = OP_FIND;
      if (installed_routes.size() > 0 && $urandom_range(99) < 70) begin
        known = installed_routes[$urandom_range(installed_routes.size() - 1)];
        w.address = known.address;
        w.net_mask = known.net_mask;
      end
    end else if (roll < 98) begin
      w.kind = OP_GET;
    end else begin
      w.kind = FIRST_UNUSED_KIND + 3'($urandom_range(2));
    end
    // aim most slot indexes at the table, a few past its end
    roll = $urandom_range(9);
    if (roll < 8) w.slot = 8'($urandom_range(ENTRIES - 1));
    else if (roll == 8) w.slot = 8'($urandom_range(255, ENTRIES));
    return w;
  endfunction

  // Idle at random, then hold the word until it is accepted.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.kind == OP_ADD) begin
      installed_routes.push_back(w);
      if (installed_routes.size() > ROUTE_MEMORY) void'(installed_routes.pop_front());
    end
  endtask

  task automatic run_directed();
    send_word(make_req(OP_GET,    32'h0,          32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_REMOVE, 32'h0,          32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h0A01_0203,  32'h0,          32'h0, 4'd0, 8'd0));
    // default route, directly connected
    send_word(make_req(OP_ADD,    32'h0,          32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_ADD,    32'h0A00_0000,  32'hFF00_0000,  32'hFFFF_FFFF, 4'd15, 8'd255));
    send_word(make_req(OP_ADD,    32'h0A01_0000,  32'hFFFF_0000,  32'hC0A8_0001, 4'd3, 8'd0));
    send_word(make_req(OP_ADD,    32'h0A01_0200,  32'hFFFF_FF00,  32'hC0A8_0002, 4'd5, 8'd0));
    send_word(make_req(OP_ADD,    32'h0A01_0203,  32'hFFFF_FFFF,  32'h0, 4'd9, 8'd0));
    // non-contiguous mask, ties the /16 on some addresses
    send_word(make_req(OP_ADD,    32'h0A00_0200,  32'hFF00_FF00,  32'h0101_0101, 4'd2, 8'd0));
    send_word(make_req(OP_ADD,    32'h0A00_0000,  32'hFF00_0000,  32'h0202_0202, 4'd7, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h0A01_0203,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h0A01_0204,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h0A09_0207,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h0AC8_0001,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'hFFFF_FFFF,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_FIND,   32'h0A01_0000,  32'hFFFF_0000,  32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_FIND,   32'h0A01_0000,  32'hFFFF_FF00,  32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_GET,    32'h0,          32'h0,          32'h0, 4'd0, 8'd3));
    send_word(make_req(OP_GET,    32'h0,          32'h0,          32'h0, 4'd0, 8'(ENTRIES)));
    send_word(make_req(OP_GET,    32'h0,          32'h0,          32'h0, 4'd0, 8'd255));
    send_word(make_req(OP_REMOVE, 32'h0,          32'h0,          32'h0, 4'd0, 8'd1));
    send_word(make_req(OP_LOOKUP, 32'h0AC8_0001,  32'h0,          32'h0, 4'd0, 8'd0));
    send_word(make_req(OP_REMOVE, 32'h0,          32'h0,          32'h0, 4'd0, 8'd1));
    send_word(make_req(OP_REMOVE, 32'h0,          32'h0,          32'h0, 4'd0, 8'd200));
    for (int k = 0; k < 3; k++)
      send_word(make_req(FIRST_UNUSED_KIND + 3'(k), $urandom, $urandom, $urandom,
                         4'hF, 8'd2));
    // refill the freed slot with per-byte partial prefixes
    send_word(make_req(OP_ADD,    32'h8040_2010,  32'h80C0_E0F0,  32'h0, 4'd1, 8'd0));
    send_word(make_req(OP_LOOKUP, 32'h807F_3F1F,  32'h0,          32'h0, 4'd0, 8'd0));
  endtask

  initial begin
    int issued;
    issued = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 8;  recv_stall_pct = 68; end
        1:       begin send_idle_pct = 68; recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (phase == 0) run_directed();
      // alternate bursts that fill the table and bursts that drain it
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_word(random_request(((issued / BURST_LEN) % 2) == 0));
        issued++;
      end
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2 * (ENTRIES + 2)) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
